// File: rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // Hue range and fixed-point scales (fractions are scaled by 255)
    localparam int unsigned HUE_MAX     = 359;
    localparam int unsigned SECTOR_DEG  = 60;
    localparam int unsigned FULL        = 255;
    localparam int unsigned QT_SCALE    = SECTOR_DEG * FULL;

    // floor(2^RECIP_SHIFT / QT_SCALE): estimate is exact or one low
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_QT    = 280716;

    typedef logic [2:0] sector_t;

    // Hue sectors, 60 degrees each
    localparam sector_t SEC_RY = 3'd0;  // red to yellow
    localparam sector_t SEC_YG = 3'd1;  // yellow to green
    localparam sector_t SEC_GC = 3'd2;  // green to cyan
    localparam sector_t SEC_CB = 3'd3;  // cyan to blue
    localparam sector_t SEC_BM = 3'd4;  // blue to magenta
    localparam sector_t SEC_MR = 3'd5;  // magenta to red

    // Stage 1 result: sector plus the small products feeding q and t
    typedef struct packed {
        sector_t     sector;
        logic [7:0]  v;
        logic [7:0]  s_inv;
        logic [13:0] hf_s;
        logic [13:0] rest_s;
    } front_t;

    // Stage 2 result: numerators of p, q and t
    typedef struct packed {
        sector_t     sector;
        logic [7:0]  v;
        logic [15:0] p_num;
        logic [21:0] q_num;
        logic [21:0] t_num;
    } prod_t;

    // First hue of a sector
    function automatic logic [8:0] sector_base(input sector_t sec);
        logic [8:0] base;
        base = 9'(int'(sec) * SECTOR_DEG);
        return base;
    endfunction

endpackage

// File: rtl/hsv2rgb_if.sv
`timescale 1ns / 1ps

// HSV pixel channel
interface hsv2rgb_hsv_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] hue_deg;
    logic [7:0]        saturation;
    logic [7:0]        brightness;

    modport source (output valid, output hue_deg, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue_deg, input saturation, input brightness,
                    output ready);
endinterface

// RGB pixel channel
interface hsv2rgb_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/hsv2rgb_front.sv
`timescale 1ns / 1ps

module hsv2rgb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [9:0]  hue_deg,
    input  logic [7:0]         saturation,
    input  logic [7:0]         brightness,
    output logic               out_valid,
    input  logic               out_ready,
    output hsv2rgb_pkg::front_t out_data
);
    import hsv2rgb_pkg::*;

    logic       en;
    logic [8:0] hue_c;
    sector_t    sec;
    logic [5:0] hf;
    logic [5:0] hf_rest;
    logic       vld_reg;
    logic       vld_next;
    front_t     data_reg;
    front_t     data_next;

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    // Clamp hue: negative to zero, above range to the top
    always_comb
    begin
        if (hue_deg[9])
            hue_c = '0;
        else if (hue_deg[8:0] > 9'(HUE_MAX))
            hue_c = 9'(HUE_MAX);
        else
            hue_c = hue_deg[8:0];
    end

    // Sector by compare chain, offset inside the sector
    always_comb
    begin
        if (hue_c < 9'(SECTOR_DEG))
            sec = SEC_RY;
        else if (hue_c < 9'(2 * SECTOR_DEG))
            sec = SEC_YG;
        else if (hue_c < 9'(3 * SECTOR_DEG))
            sec = SEC_GC;
        else if (hue_c < 9'(4 * SECTOR_DEG))
            sec = SEC_CB;
        else if (hue_c < 9'(5 * SECTOR_DEG))
            sec = SEC_BM;
        else
            sec = SEC_MR;
    end

    assign hf      = 6'(hue_c - sector_base(sec));
    assign hf_rest = 6'(SECTOR_DEG) - hf;

    always_comb
    begin
        data_next.sector = sec;
        data_next.v      = brightness;
        data_next.s_inv  = 8'(FULL) - saturation;
        data_next.hf_s   = 14'(hf) * 14'(saturation);
        data_next.rest_s = 14'(hf_rest) * 14'(saturation);
    end

    assign vld_next = en ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/hsv2rgb_mult.sv
`timescale 1ns / 1ps

module hsv2rgb_mult (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsv2rgb_pkg::front_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hsv2rgb_pkg::prod_t  out_data
);
    import hsv2rgb_pkg::*;

    logic  en;
    logic  vld_reg;
    logic  vld_next;
    prod_t data_reg;
    prod_t data_next;

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    // Scale v by the three fractional factors
    always_comb
    begin
        data_next.sector = in_data.sector;
        data_next.v      = in_data.v;
        data_next.p_num  = 16'(in_data.v) * 16'(in_data.s_inv);
        data_next.q_num  = 22'(in_data.v) * 22'(14'(QT_SCALE) - in_data.hf_s);
        data_next.t_num  = 22'(in_data.v) * 22'(14'(QT_SCALE) - in_data.rest_s);
    end

    assign vld_next = en ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/hsv2rgb_div.sv
`timescale 1ns / 1ps

module hsv2rgb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsv2rgb_pkg::prod_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);
    import hsv2rgb_pkg::*;

    typedef struct packed {
        sector_t     sector;
        logic [7:0]  v;
        logic [7:0]  p;
        logic [21:0] q_num;
        logic [7:0]  q_est;
        logic [21:0] t_num;
        logic [7:0]  t_est;
    } est_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    logic        a_en;
    logic        b_en;
    logic [16:0] p_sum;
    logic [40:0] q_prod;
    logic [40:0] t_prod;
    logic [21:0] q_rem;
    logic [21:0] t_rem;
    logic [7:0]  q_fix;
    logic [7:0]  t_fix;
    logic        a_vld_reg;
    logic        a_vld_next;
    est_t        a_reg;
    est_t        a_next;
    logic        b_vld_reg;
    logic        b_vld_next;
    pix_t        b_reg;
    pix_t        b_next;

    assign b_en     = !b_vld_reg || out_ready;
    assign a_en     = !a_vld_reg || b_en;
    assign in_ready = a_en;

    // Divide by 255 exactly for numerators up to 255*255
    assign p_sum  = 17'(in_data.p_num) + 17'(in_data.p_num >> 8) + 17'd1;

    // Reciprocal estimate of the divide by 15300
    assign q_prod = 41'(in_data.q_num) * 41'(RECIP_QT);
    assign t_prod = 41'(in_data.t_num) * 41'(RECIP_QT);

    always_comb
    begin
        a_next.sector = in_data.sector;
        a_next.v      = in_data.v;
        a_next.p      = p_sum[15:8];
        a_next.q_num  = in_data.q_num;
        a_next.q_est  = q_prod[RECIP_SHIFT + 7:RECIP_SHIFT];
        a_next.t_num  = in_data.t_num;
        a_next.t_est  = t_prod[RECIP_SHIFT + 7:RECIP_SHIFT];
    end

    // Correct an estimate that came out one low
    assign q_rem = a_reg.q_num - 22'(a_reg.q_est) * 22'(QT_SCALE);
    assign t_rem = a_reg.t_num - 22'(a_reg.t_est) * 22'(QT_SCALE);
    assign q_fix = a_reg.q_est + 8'(q_rem >= 22'(QT_SCALE));
    assign t_fix = a_reg.t_est + 8'(t_rem >= 22'(QT_SCALE));

    // Sector mux
    always_comb
    begin
        case (a_reg.sector)
            SEC_RY:  b_next = '{r: a_reg.v, g: t_fix,   b: a_reg.p};
            SEC_YG:  b_next = '{r: q_fix,   g: a_reg.v, b: a_reg.p};
            SEC_GC:  b_next = '{r: a_reg.p, g: a_reg.v, b: t_fix};
            SEC_CB:  b_next = '{r: a_reg.p, g: q_fix,   b: a_reg.v};
            SEC_BM:  b_next = '{r: t_fix,   g: a_reg.p, b: a_reg.v};
            default: b_next = '{r: a_reg.v, g: a_reg.p, b: q_fix};
        endcase
    end

    assign a_vld_next = a_en ? in_valid : a_vld_reg;
    assign b_vld_next = b_en ? a_vld_reg : b_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
            a_reg <= a_next;
        if (b_en && a_vld_reg)
            b_reg <= b_next;
    end

    assign out_valid = b_vld_reg;
    assign red       = b_reg.r;
    assign green     = b_reg.g;
    assign blue      = b_reg.b;

endmodule

// File: rtl/hsv_to_rgb_pixel_converter_top.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter. Takes one pixel per clock (hue in signed degrees,
// clamped to 0..359; saturation and value as 8-bit fractions, 255 = 1.0) and
// returns the truncated 8-bit red, green and blue levels. The path is four
// register stages: hue clamp and sector split with the small hue-offset
// products, the value multiplies, a reciprocal estimate of the divides, then
// remainder correction and the sector mux. Output valid rises once the pixel has
// passed the front, multiply and both divide registers in turn, and throughput
// is one pixel per cycle while the output side takes transfers.
// Each stage holds its pixel when the next one is full, so hsv.ready follows
// rgb.ready combinationally through the stages.
module hsv_to_rgb_pixel_converter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    hsv2rgb_hsv_if.sink          hsv,
    hsv2rgb_rgb_if.source        rgb
);
    import hsv2rgb_pkg::*;

    logic   f_valid;
    logic   f_ready;
    front_t f_data;
    logic   m_valid;
    logic   m_ready;
    prod_t  m_data;

    hsv2rgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hsv.valid),
        .in_ready   (hsv.ready),
        .hue_deg    (hsv.hue_deg),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_data   (f_data)
    );

    hsv2rgb_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    hsv2rgb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_ready  (m_ready),
        .in_data   (m_data),
        .out_valid (rgb.valid),
        .out_ready (rgb.ready),
        .red       (rgb.red),
        .green     (rgb.green),
        .blue      (rgb.blue)
    );

endmodule

// File: rtl/hsv2rgb_chk.sv
`timescale 1ns / 1ps

module hsv2rgb_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic signed [9:0] hue_deg,
    input logic [7:0]        saturation,
    input logic [7:0]        brightness,
    input logic              out_valid,
    input logic              out_ready,
    input logic [7:0]        red,
    input logic [7:0]        green,
    input logic [7:0]        blue
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Nothing comes out while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
                                    && $stable(blue))
        else $error("stalled result changed");

    // Zero saturation gives a grey of level v
    // (output transfer is that of the pixel whose input transfer is looked back to, no stall between)
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
        && $past(in_xfer, 4) && $past(saturation, 4) == 8'd0
        |-> red == $past(brightness, 4) && green == $past(brightness, 4)
            && blue == $past(brightness, 4))
        else $error("grey pixel wrong");

    // Negative hue clamps to pure red at full saturation
    a_neg_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3)
        && $past(in_xfer, 4) && $past(hue_deg[9], 4) && $past(saturation, 4) == 8'd255
        |-> red == $past(brightness, 4) && green == 8'd0 && blue == 8'd0)
        else $error("negative hue not clamped");

endmodule

bind hsv_to_rgb_pixel_converter_top hsv2rgb_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (hsv.valid),
    .in_ready   (hsv.ready),
    .hue_deg    (hsv.hue_deg),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .out_valid  (rgb.valid),
    .out_ready  (rgb.ready),
    .red        (rgb.red),
    .green      (rgb.green),
    .blue       (rgb.blue)
);
